[src/fps_pkg.sv]
// Shared types, constants and Fibonacci table for the Fibonacci peak search block.
package fps_pkg;

    localparam int SEARCH_SPAN_DEF = 1597;
    localparam int FIB_STEPS_DEF   = 16;
    localparam int LINEAR_MAX      = 5;

    localparam int POS_W     = 11;
    localparam int VAL_W     = 30;
    localparam int PROBE_W   = 12;
    localparam int SAMPLE_W  = 32;
    localparam int FIB_IDX_W = 4;
    localparam int EPOCH_W   = 4;
    localparam int PHASE_W   = 3;

    typedef logic [POS_W-1:0]            pos_t;
    typedef logic [VAL_W-1:0]            val_t;
    typedef logic [PROBE_W-1:0]          probe_t;
    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef logic [FIB_IDX_W-1:0]        fib_idx_t;
    typedef logic [EPOCH_W-1:0]          epoch_t;
    typedef logic [PHASE_W-1:0]          phase_t;

    localparam probe_t NONE_POS = '1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_REPLY = 1'b1;

    localparam logic KIND_PROBE = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    localparam phase_t PH_IDLE   = 3'd0;
    localparam phase_t PH_LIN    = 3'd1;
    localparam phase_t PH_INIT_L = 3'd2;
    localparam phase_t PH_INIT_R = 3'd3;
    localparam phase_t PH_LOOP   = 3'd4;
    localparam phase_t PH_TAIL   = 3'd5;

    localparam pos_t FIB_TAB [16] = '{
        11'd1,   11'd2,   11'd3,   11'd5,   11'd8,   11'd13,  11'd21,  11'd34,
        11'd55,  11'd89,  11'd144, 11'd233, 11'd377, 11'd610, 11'd987, 11'd1597
    };

    typedef struct packed {
        logic start;
        logic reply_write;
        logic clear_step;
        logic mem_read;
        logic consume;
        logic emit_probe;
        logic emit_final;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_start;
        logic phase_idle;
        logic clear_needed;
        logic clear_last;
        logic need_zero;
        logic beyond;
        logic memo_range;
        logic memo_hit;
        logic out_busy;
    } dp_status_t;

endpackage

[src/fps_ctrl.sv]
// Sequencer for the Fibonacci peak search: handshake, memo clearing and probe resolution.
module fps_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fps_pkg::dp_status_t    status,
    output fps_pkg::ctrl_cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_MEMRD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.req_start)
                    begin
                        cmd.start  = 1'b1;
                        state_next = status.clear_needed ? ST_CLEAR : ST_EVAL;
                    end
                    else if (!status.phase_idle)
                    begin
                        cmd.reply_write = 1'b1;
                        state_next      = ST_EVAL;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.need_zero)
                begin
                    if (!status.out_busy)
                    begin
                        cmd.emit_final = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (status.beyond)
                begin
                    cmd.consume = 1'b1;
                end
                else if (status.memo_range)
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = ST_MEMRD;
                end
                else if (!status.out_busy)
                begin
                    cmd.emit_probe = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_MEMRD:
            begin
                if (status.memo_hit)
                begin
                    cmd.consume = 1'b1;
                    state_next  = ST_EVAL;
                end
                else if (!status.out_busy)
                begin
                    cmd.emit_probe = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/fps_datapath.sv]
// Search registers, epoch-tagged value memo and output register of the Fibonacci peak search.
module fps_datapath #(
    parameter int SEARCH_SPAN = fps_pkg::SEARCH_SPAN_DEF,
    parameter int FIB_STEPS   = fps_pkg::FIB_STEPS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fps_pkg::ctrl_cmd_t     cmd,
    output fps_pkg::dp_status_t    status,
    input  logic                   req_type,
    input  fps_pkg::pos_t          seq_length,
    input  fps_pkg::val_t          probe_value,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   result_kind,
    output fps_pkg::pos_t          probe_position,
    output fps_pkg::val_t          best_value
);

    localparam int MEMO_DEPTH = SEARCH_SPAN + 4;
    localparam int MEMO_AW    = $clog2(MEMO_DEPTH);
    localparam int STEP_W     = $clog2(FIB_STEPS);
    localparam int ENTRY_W    = fps_pkg::EPOCH_W + fps_pkg::VAL_W;

    localparam logic [MEMO_AW-1:0] CLEAR_LAST = MEMO_AW'(MEMO_DEPTH - 1);
    localparam fps_pkg::pos_t      MEMO_LIMIT = fps_pkg::pos_t'(MEMO_DEPTH);
    localparam fps_pkg::pos_t      SPAN_POS   = fps_pkg::pos_t'(SEARCH_SPAN);
    localparam fps_pkg::pos_t      INIT_RIGHT = fps_pkg::FIB_TAB[FIB_STEPS-2];
    localparam fps_pkg::pos_t      INIT_LEFT  = SPAN_POS - INIT_RIGHT;
    localparam logic [STEP_W-1:0]  STEP_INIT  = STEP_W'(FIB_STEPS - 4);
    localparam logic [STEP_W-1:0]  STEP_TOP   = STEP_W'(FIB_STEPS - 1);
    localparam fps_pkg::epoch_t    EPOCH_MAX  = '1;

    // Search state
    fps_pkg::pos_t     bracket_low_reg,  bracket_low_next;
    fps_pkg::pos_t     bracket_high_reg, bracket_high_next;
    fps_pkg::probe_t   left_probe_reg,   left_probe_next;
    fps_pkg::probe_t   right_probe_reg,  right_probe_next;
    fps_pkg::sample_t  left_sample_reg,  left_sample_next;
    fps_pkg::sample_t  right_sample_reg, right_sample_next;
    fps_pkg::val_t     running_best_reg, running_best_next;
    logic [STEP_W-1:0] fib_step_reg,     fib_step_next;
    fps_pkg::phase_t   phase_reg,        phase_next;
    fps_pkg::probe_t   scan_cursor_reg,  scan_cursor_next;
    fps_pkg::pos_t     stored_length_reg, stored_length_next;

    // Memo bookkeeping
    fps_pkg::epoch_t    epoch_reg,     epoch_next;
    logic               dirty_reg,     dirty_next;
    logic [MEMO_AW-1:0] clear_cnt_reg, clear_cnt_next;
    logic [ENTRY_W-1:0] memo [MEMO_DEPTH];
    logic [ENTRY_W-1:0] mem_rd_reg;

    // Output register
    logic              out_valid_reg;
    logic              result_kind_reg;
    fps_pkg::pos_t     probe_position_reg;
    fps_pkg::val_t     best_value_reg;

    // Working values
    logic [STEP_W-1:0] fib_k;
    fps_pkg::pos_t     fib_val;
    fps_pkg::pos_t     pos;
    fps_pkg::sample_t  neg_pos;
    fps_pkg::sample_t  mem_val;
    fps_pkg::sample_t  cur_val;
    fps_pkg::sample_t  best_s;
    fps_pkg::sample_t  pair_max;
    fps_pkg::probe_t   lp_c, rp_c;
    fps_pkg::sample_t  ls_c, rs_c;
    fps_pkg::val_t     one_best, split_best;
    fps_pkg::pos_t     sbl, sbh;
    fps_pkg::probe_t   slp, srp;
    fps_pkg::sample_t  sls, srs;
    logic              memo_ok;

    // Position the current phase needs; zero ends the search
    always_comb
    begin
        fib_k   = (int'(fib_step_reg) < FIB_STEPS) ? fib_step_reg : STEP_TOP;
        fib_val = fps_pkg::FIB_TAB[fps_pkg::fib_idx_t'(fib_k)];
        unique case (phase_reg)
            fps_pkg::PH_LIN:
                pos = (scan_cursor_reg <= {1'b0, stored_length_reg})
                      ? scan_cursor_reg[fps_pkg::POS_W-1:0] : '0;
            fps_pkg::PH_INIT_L:
                pos = left_probe_reg[fps_pkg::POS_W-1:0];
            fps_pkg::PH_INIT_R:
                pos = right_probe_reg[fps_pkg::POS_W-1:0];
            fps_pkg::PH_LOOP:
                pos = (left_probe_reg == fps_pkg::NONE_POS)
                      ? bracket_low_reg + fib_val : bracket_high_reg - fib_val;
            fps_pkg::PH_TAIL:
                pos = (scan_cursor_reg < {1'b0, bracket_high_reg})
                      ? scan_cursor_reg[fps_pkg::POS_W-1:0] : '0;
            default:
                pos = '0;
        endcase
    end

    assign memo_ok = (pos < MEMO_LIMIT);
    assign neg_pos = fps_pkg::sample_t'(0) - fps_pkg::sample_t'(pos);
    assign mem_val = fps_pkg::sample_t'(mem_rd_reg[fps_pkg::VAL_W-1:0]);

    assign status.req_start    = (req_type == fps_pkg::REQ_START);
    assign status.phase_idle   = (phase_reg == fps_pkg::PH_IDLE);
    assign status.clear_needed = dirty_reg || (epoch_reg == EPOCH_MAX);
    assign status.clear_last   = (clear_cnt_reg == CLEAR_LAST);
    assign status.need_zero    = (pos == '0);
    assign status.beyond       = (pos > stored_length_reg);
    assign status.memo_range   = memo_ok;
    assign status.memo_hit     = (mem_rd_reg[ENTRY_W-1:fps_pkg::VAL_W] == epoch_reg);
    assign status.out_busy     = out_valid_reg && !out_ready;

    // Pair update: fill the open probe, fold samples into the best, split the bracket
    always_comb
    begin
        cur_val = status.beyond ? neg_pos : mem_val;
        best_s  = fps_pkg::sample_t'(running_best_reg);
        lp_c    = left_probe_reg;
        rp_c    = right_probe_reg;
        ls_c    = left_sample_reg;
        rs_c    = right_sample_reg;
        if (phase_reg == fps_pkg::PH_INIT_R)
        begin
            rs_c = cur_val;
        end
        else if (left_probe_reg == fps_pkg::NONE_POS)
        begin
            lp_c = {1'b0, pos};
            ls_c = cur_val;
        end
        else
        begin
            rp_c = {1'b0, pos};
            rs_c = cur_val;
        end
        one_best   = (cur_val > best_s) ? cur_val[fps_pkg::VAL_W-1:0] : running_best_reg;
        pair_max   = (ls_c > rs_c) ? ls_c : rs_c;
        split_best = (pair_max > best_s) ? pair_max[fps_pkg::VAL_W-1:0] : running_best_reg;
        sbl = bracket_low_reg;
        sbh = bracket_high_reg;
        if (ls_c < rs_c)
        begin
            sbl = lp_c[fps_pkg::POS_W-1:0];
            slp = rp_c;
            sls = rs_c;
            srp = fps_pkg::NONE_POS;
            srs = -fps_pkg::sample_t'(1);
        end
        else
        begin
            sbh = rp_c[fps_pkg::POS_W-1:0];
            srp = lp_c;
            srs = ls_c;
            slp = fps_pkg::NONE_POS;
            sls = -fps_pkg::sample_t'(1);
        end
    end

    always_comb
    begin
        bracket_low_next   = bracket_low_reg;
        bracket_high_next  = bracket_high_reg;
        left_probe_next    = left_probe_reg;
        right_probe_next   = right_probe_reg;
        left_sample_next   = left_sample_reg;
        right_sample_next  = right_sample_reg;
        running_best_next  = running_best_reg;
        fib_step_next      = fib_step_reg;
        phase_next         = phase_reg;
        scan_cursor_next   = scan_cursor_reg;
        stored_length_next = stored_length_reg;
        epoch_next         = epoch_reg;
        dirty_next         = dirty_reg;
        clear_cnt_next     = clear_cnt_reg;

        if (cmd.start)
        begin
            bracket_low_next   = '0;
            bracket_high_next  = SPAN_POS;
            left_probe_next    = fps_pkg::NONE_POS;
            right_probe_next   = fps_pkg::NONE_POS;
            left_sample_next   = '0;
            right_sample_next  = '0;
            running_best_next  = '0;
            fib_step_next      = STEP_INIT;
            stored_length_next = seq_length;
            if (int'(seq_length) <= fps_pkg::LINEAR_MAX)
            begin
                scan_cursor_next = fps_pkg::probe_t'(1);
                phase_next       = fps_pkg::PH_LIN;
            end
            else
            begin
                scan_cursor_next = '0;
                left_probe_next  = {1'b0, INIT_LEFT};
                right_probe_next = {1'b0, INIT_RIGHT};
                phase_next       = fps_pkg::PH_INIT_L;
            end
            // New epoch invalidates the old memo; wrap or first use needs a sweep
            if (status.clear_needed)
            begin
                epoch_next     = fps_pkg::epoch_t'(1);
                dirty_next     = 1'b0;
                clear_cnt_next = '0;
            end
            else
            begin
                epoch_next = epoch_reg + fps_pkg::epoch_t'(1);
            end
        end
        else if (cmd.clear_step)
        begin
            clear_cnt_next = clear_cnt_reg + MEMO_AW'(1);
        end
        else if (cmd.consume)
        begin
            unique case (phase_reg)
                fps_pkg::PH_LIN,
                fps_pkg::PH_TAIL:
                begin
                    running_best_next = one_best;
                    scan_cursor_next  = scan_cursor_reg + fps_pkg::probe_t'(1);
                end
                fps_pkg::PH_INIT_L:
                begin
                    left_sample_next = cur_val;
                    phase_next       = fps_pkg::PH_INIT_R;
                end
                fps_pkg::PH_INIT_R,
                fps_pkg::PH_LOOP:
                begin
                    running_best_next = split_best;
                    bracket_low_next  = sbl;
                    bracket_high_next = sbh;
                    left_probe_next   = slp;
                    left_sample_next  = sls;
                    right_probe_next  = srp;
                    right_sample_next = srs;
                    if (phase_reg == fps_pkg::PH_INIT_R)
                    begin
                        fib_step_next = STEP_INIT;
                        phase_next    = fps_pkg::PH_LOOP;
                    end
                    else if (fib_step_reg == '0)
                    begin
                        scan_cursor_next = {1'b0, sbl} + fps_pkg::probe_t'(1);
                        phase_next       = fps_pkg::PH_TAIL;
                    end
                    else
                    begin
                        fib_step_next = fib_step_reg - STEP_W'(1);
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else if (cmd.emit_final)
        begin
            phase_next = fps_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bracket_low_reg   <= '0;
            bracket_high_reg  <= SPAN_POS;
            left_probe_reg    <= fps_pkg::NONE_POS;
            right_probe_reg   <= fps_pkg::NONE_POS;
            left_sample_reg   <= '0;
            right_sample_reg  <= '0;
            running_best_reg  <= '0;
            fib_step_reg      <= STEP_INIT;
            phase_reg         <= fps_pkg::PH_IDLE;
            scan_cursor_reg   <= '0;
            stored_length_reg <= '0;
            epoch_reg         <= fps_pkg::epoch_t'(1);
            dirty_reg         <= 1'b1;
            clear_cnt_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            bracket_low_reg   <= bracket_low_next;
            bracket_high_reg  <= bracket_high_next;
            left_probe_reg    <= left_probe_next;
            right_probe_reg   <= right_probe_next;
            left_sample_reg   <= left_sample_next;
            right_sample_reg  <= right_sample_next;
            running_best_reg  <= running_best_next;
            fib_step_reg      <= fib_step_next;
            phase_reg         <= phase_next;
            scan_cursor_reg   <= scan_cursor_next;
            stored_length_reg <= stored_length_next;
            epoch_reg         <= epoch_next;
            dirty_reg         <= dirty_next;
            clear_cnt_reg     <= clear_cnt_next;
            if (cmd.emit_probe || cmd.emit_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Memo: one write port (sweep or reply), one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            memo[clear_cnt_reg] <= '0;
        end
        else if (cmd.reply_write && (pos != '0) && memo_ok)
        begin
            memo[pos[MEMO_AW-1:0]] <= {epoch_reg, probe_value};
        end
        if (cmd.mem_read)
        begin
            mem_rd_reg <= memo[pos[MEMO_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_probe)
        begin
            result_kind_reg    <= fps_pkg::KIND_PROBE;
            probe_position_reg <= pos;
            best_value_reg     <= '0;
        end
        else if (cmd.emit_final)
        begin
            result_kind_reg    <= fps_pkg::KIND_FINAL;
            probe_position_reg <= '0;
            best_value_reg     <= running_best_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = result_kind_reg;
    assign probe_position = probe_position_reg;
    assign best_value     = best_value_reg;

endmodule

[src/fibonacci_peak_search.sv]
// Top level of the Fibonacci peak search: sequencer plus search datapath.
// A start at length zero gives its final result without asking for a probe; otherwise positions
// are resolved, skipping those beyond the length and answering memo hits internally, until one
// must be asked from outside. Throughput: one item at a time, the next taken in the cycle after
// the last result is loaded. The first start after reset, and every 15th start after it, sweep
// all SEARCH_SPAN+4 memo entries first. Reset: asynchronous active low; search goes idle,
// output empty, memo marked for a sweep.
module fibonacci_peak_search #(
    parameter int SEARCH_SPAN = fps_pkg::SEARCH_SPAN_DEF,
    parameter int FIB_STEPS   = fps_pkg::FIB_STEPS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           req_type,
    input  fps_pkg::pos_t  seq_length,
    input  fps_pkg::val_t  probe_value,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           result_kind,
    output fps_pkg::pos_t  probe_position,
    output fps_pkg::val_t  best_value
);

    // Commands from the sequencer, status back from the datapath
    fps_pkg::ctrl_cmd_t  cmd;
    fps_pkg::dp_status_t status;

    // Sequencer: accept an item only when idle, then resolve positions until one must be
    // asked from outside or the search ends; hold a result while the output register is full.
    fps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: bracket, probe pair, running best, epoch-tagged memo and output register.
    fps_datapath #(
        .SEARCH_SPAN (SEARCH_SPAN),
        .FIB_STEPS   (FIB_STEPS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .req_type       (req_type),
        .seq_length     (seq_length),
        .probe_value    (probe_value),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .result_kind    (result_kind),
        .probe_position (probe_position),
        .best_value     (best_value)
    );

endmodule
